@@ hdl/sng_pkg.sv @@
// ----------------------------------------------------------------------------
// sng_pkg
// Shared constants, types and the controller command bundle for the
// smooth number generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sng_pkg;

    localparam int K_MAX   = 128;
    localparam int N_MAX   = 4096;

    localparam int IDX_W   = $clog2(K_MAX);   // prime table slot
    localparam int CNT_W   = IDX_W + 1;       // prime count, holds K_MAX
    localparam int PTR_W   = $clog2(N_MAX);   // merge pointer / sequence address
    localparam int POS_W   = PTR_W + 1;       // position n, holds N_MAX
    localparam int PRIME_W = 10;
    localparam int VALUE_W = 31;
    localparam int PROD_W  = VALUE_W + PRIME_W;

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = {VALUE_W{1'b1}};

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_UPDATE,
        ST_UPDATE_WAIT,
        ST_STORE,
        ST_FETCH,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic             load;          // write prime table
        logic             start;         // seq[0] = 1, clear flag, first pass
        logic             issue_scan;    // candidate pass, slot = slot
        logic             issue_update;  // pointer advance pass, slot = slot
        logic             store;         // write seq[entry] = min
        logic             fetch;         // read seq[entry]
        logic             emit;          // load output register
        logic [IDX_W-1:0] slot;
        logic [PTR_W-1:0] entry;
    } cmd_t;

endpackage

`default_nettype wire

@@ hdl/sng_datapath.sv @@
// ----------------------------------------------------------------------------
// sng_datapath
// Prime table, merge pointers, candidate and sequence memories, the
// candidate multiplier and the running minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module sng_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sng_pkg::cmd_t                 cmd,
    input  wire logic [sng_pkg::IDX_W-1:0]     prime_index,
    input  wire logic [sng_pkg::PRIME_W-1:0]   prime_value,
    output logic                               pipe_busy,
    output logic [sng_pkg::VALUE_W-1:0]        result_value,
    output logic                               status
);

    logic [sng_pkg::PRIME_W-1:0] prime_mem [sng_pkg::K_MAX];
    logic [sng_pkg::PTR_W-1:0]   ptr_mem   [sng_pkg::K_MAX];
    logic [sng_pkg::PROD_W-1:0]  cand_mem  [sng_pkg::K_MAX];
    logic [sng_pkg::VALUE_W-1:0] seq_mem   [sng_pkg::N_MAX];

    logic [sng_pkg::PRIME_W-1:0] prime_rd_reg;
    logic [sng_pkg::PRIME_W-1:0] prime_s2_reg;
    logic [sng_pkg::PTR_W-1:0]   ptr_rd_reg;
    logic [sng_pkg::PROD_W-1:0]  cand_rd_reg;
    logic [sng_pkg::VALUE_W-1:0] seq_rd_reg;
    logic [sng_pkg::PROD_W-1:0]  prod_reg;
    logic [sng_pkg::PROD_W-1:0]  best_reg;
    logic [sng_pkg::VALUE_W-1:0] result_value_reg;
    logic                        status_reg;

    logic [sng_pkg::IDX_W-1:0]   s1_slot_reg;
    logic [sng_pkg::IDX_W-1:0]   s2_slot_reg;
    logic [sng_pkg::IDX_W-1:0]   s3_slot_reg;
    logic [sng_pkg::IDX_W-1:0]   u1_slot_reg;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic u1_valid_reg;
    logic first_reg;
    logic flag_reg;

    logic [sng_pkg::PTR_W-1:0]   ptr_eff;
    logic [sng_pkg::PTR_W-1:0]   seq_raddr;
    logic [sng_pkg::VALUE_W-1:0] seq_wdata;
    logic                        seq_we;
    logic                        best_over;

    // pointers from an earlier compute are stale during the first entry
    assign ptr_eff   = first_reg ? '0 : ptr_rd_reg;
    assign seq_raddr = cmd.fetch ? cmd.entry : ptr_eff;
    assign best_over = best_reg > sng_pkg::PROD_W'(sng_pkg::VALUE_LIMIT);
    assign seq_we    = cmd.start | cmd.store;
    assign seq_wdata = cmd.start ? sng_pkg::VALUE_W'(1)
                     : (best_over ? sng_pkg::VALUE_LIMIT : best_reg[sng_pkg::VALUE_W-1:0]);
    assign pipe_busy = s1_valid_reg | s2_valid_reg | s3_valid_reg | u1_valid_reg;

    // prime table
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prime_mem[prime_index] <= prime_value;
        end
        prime_rd_reg <= prime_mem[cmd.slot];
    end

    // merge pointers: rewritten for every slot in each update pass
    always_ff @(posedge clk)
    begin
        if (u1_valid_reg)
        begin
            ptr_mem[u1_slot_reg] <= ptr_eff + sng_pkg::PTR_W'(cand_rd_reg == best_reg);
        end
        ptr_rd_reg <= ptr_mem[cmd.slot];
    end

    // candidates of the current entry
    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            cand_mem[s3_slot_reg] <= prod_reg;
        end
        cand_rd_reg <= cand_mem[cmd.slot];
    end

    // sequence store
    always_ff @(posedge clk)
    begin
        if (seq_we)
        begin
            seq_mem[cmd.start ? '0 : cmd.entry] <= seq_wdata;
        end
        if (s1_valid_reg || cmd.fetch)
        begin
            seq_rd_reg <= seq_mem[seq_raddr];
        end
    end

    // multiplier and minimum
    always_ff @(posedge clk)
    begin
        prime_s2_reg <= prime_rd_reg;
        prod_reg     <= sng_pkg::PROD_W'(seq_rd_reg) * sng_pkg::PROD_W'(prime_s2_reg);
        s1_slot_reg  <= cmd.slot;
        s2_slot_reg  <= s1_slot_reg;
        s3_slot_reg  <= s2_slot_reg;
        u1_slot_reg  <= cmd.slot;
        if (s3_valid_reg && (s3_slot_reg == '0 || prod_reg < best_reg))
        begin
            best_reg <= prod_reg;
        end
        if (cmd.emit)
        begin
            result_value_reg <= seq_rd_reg;
            status_reg       <= flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            u1_valid_reg <= 1'b0;
            first_reg    <= 1'b0;
            flag_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue_scan;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            u1_valid_reg <= cmd.issue_update;
            if (cmd.start)
            begin
                first_reg <= 1'b1;
                flag_reg  <= 1'b0;
            end
            else if (cmd.store)
            begin
                first_reg <= 1'b0;
                if (best_over)
                begin
                    flag_reg <= 1'b1;
                end
            end
        end
    end

    assign result_value = result_value_reg;
    assign status       = status_reg;

    // scan and update passes never overlap
    a_pass_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue_scan |-> !u1_valid_reg && !cmd.issue_update)
        else $error("scan issued during pointer update");

    // the minimum is final before it is stored
    a_store_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !pipe_busy)
        else $error("entry stored with candidates in flight");

    // a new compute starts with a clean overflow flag and fresh pointers
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !flag_reg && first_reg)
        else $error("compute start did not reset flag");

    // pointer update reads a candidate written in the preceding scan
    a_update_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue_update |-> !s3_valid_reg)
        else $error("update overlaps candidate write");

endmodule

`default_nettype wire

@@ hdl/sng_controller.sv @@
// ----------------------------------------------------------------------------
// sng_controller
// Sequencer for load and compute items, the prime count register and the
// output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sng_controller (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        operation,
    input  wire logic [sng_pkg::POS_W-1:0]   sequence_position,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [sng_pkg::CNT_W-1:0]   cfg_data,
    input  wire logic                        pipe_busy,
    output sng_pkg::cmd_t                    cmd
);

    sng_pkg::state_t state_reg, state_next;

    logic [sng_pkg::CNT_W-1:0] prime_count_reg;
    logic [sng_pkg::CNT_W-1:0] k_reg, k_next;
    logic [sng_pkg::POS_W-1:0] n_reg, n_next;
    logic [sng_pkg::PTR_W-1:0] i_reg, i_next;
    logic [sng_pkg::IDX_W-1:0] j_reg, j_next;
    logic                      out_valid_reg;

    logic [sng_pkg::CNT_W-1:0] k_eff;
    logic [sng_pkg::POS_W-1:0] n_eff;
    logic                      accept;
    logic                      last_slot;

    assign k_eff = (prime_count_reg == '0) ? sng_pkg::CNT_W'(1)
                 : (prime_count_reg > sng_pkg::CNT_W'(sng_pkg::K_MAX))
                   ? sng_pkg::CNT_W'(sng_pkg::K_MAX) : prime_count_reg;
    assign n_eff = (sequence_position == '0) ? sng_pkg::POS_W'(1)
                 : (sequence_position > sng_pkg::POS_W'(sng_pkg::N_MAX))
                   ? sng_pkg::POS_W'(sng_pkg::N_MAX) : sequence_position;

    assign in_stall  = (state_reg != sng_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign last_slot = ({1'b0, j_reg} == k_reg - sng_pkg::CNT_W'(1));
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.slot   = j_reg;
        cmd.entry  = '0;

        unique case (state_reg)
            sng_pkg::ST_IDLE:
            begin
                if (accept && operation == sng_pkg::OP_LOAD)
                begin
                    cmd.load = 1'b1;
                end
                else if (accept && operation == sng_pkg::OP_COMPUTE)
                begin
                    k_next     = k_eff;
                    n_next     = n_eff;
                    state_next = sng_pkg::ST_INIT;
                end
            end
            sng_pkg::ST_INIT:
            begin
                cmd.start = 1'b1;
                i_next    = '0;
                j_next    = '0;
                state_next = (n_reg == sng_pkg::POS_W'(1)) ? sng_pkg::ST_FETCH
                                                            : sng_pkg::ST_SCAN;
            end
            sng_pkg::ST_SCAN:
            begin
                cmd.issue_scan = 1'b1;
                j_next = j_reg + sng_pkg::IDX_W'(1);
                if (last_slot)
                begin
                    state_next = sng_pkg::ST_SCAN_WAIT;
                end
            end
            sng_pkg::ST_SCAN_WAIT:
            begin
                j_next = '0;
                if (!pipe_busy)
                begin
                    state_next = sng_pkg::ST_UPDATE;
                end
            end
            sng_pkg::ST_UPDATE:
            begin
                cmd.issue_update = 1'b1;
                j_next = j_reg + sng_pkg::IDX_W'(1);
                if (last_slot)
                begin
                    state_next = sng_pkg::ST_UPDATE_WAIT;
                end
            end
            sng_pkg::ST_UPDATE_WAIT:
            begin
                j_next = '0;
                if (!pipe_busy)
                begin
                    state_next = sng_pkg::ST_STORE;
                end
            end
            sng_pkg::ST_STORE:
            begin
                cmd.store = 1'b1;
                cmd.entry = i_reg + sng_pkg::PTR_W'(1);
                i_next    = i_reg + sng_pkg::PTR_W'(1);
                state_next = ({1'b0, i_reg} + sng_pkg::POS_W'(2) == n_reg)
                           ? sng_pkg::ST_FETCH : sng_pkg::ST_SCAN;
            end
            sng_pkg::ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                cmd.entry  = sng_pkg::PTR_W'(n_reg - sng_pkg::POS_W'(1));
                state_next = sng_pkg::ST_RESULT;
            end
            sng_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sng_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sng_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sng_pkg::ST_IDLE;
            prime_count_reg <= sng_pkg::CNT_W'(1);
            k_reg           <= sng_pkg::CNT_W'(1);
            n_reg           <= sng_pkg::POS_W'(1);
            i_reg           <= '0;
            j_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (cfg_valid && cfg_ready)
            begin
                prime_count_reg <= cfg_data;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // a result is only loaded when the output register is free
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg || !out_stall)
        else $error("output register overwritten");

    // every compute item produces its result through fetch
    a_fetch_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |=> state_reg == sng_pkg::ST_RESULT)
        else $error("fetch not followed by result");

    // slot counter never passes the prime count during a pass
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue_scan || cmd.issue_update) |-> {1'b0, j_reg} < k_reg)
        else $error("slot beyond prime count");

endmodule

`default_nettype wire

@@ hdl/smooth_number_generator.sv @@
// ----------------------------------------------------------------------------
// smooth_number_generator
// Super ugly number generator using a k-pointer merge over a loaded
// prime table.
// ----------------------------------------------------------------------------
// A load item (operation 0) writes prime_value into table slot prime_index
// and the block stays idle for the next item. A compute item (operation 1)
// returns entry n-1 of the ascending sequence of numbers whose prime factors
// all come from the first prime_count table slots; status is set when any
// generated entry passed 2^31-1 (such entries are held at 2^31-1). Each new
// entry walks the k primes twice through the pointer and candidate memories,
// once to form candidates in a four-stage read-multiply-compare pipeline and
// once to advance pointers. Input is stalled during a compute; loads and the
// next item are taken while a finished result waits in the output register.
// prime_count is written through the cfg port; the user must write it only
// while the block is idle, as the block itself does not enforce this; slots
// up to k-1 must have been loaded before a compute.
// ----------------------------------------------------------------------------
`default_nettype none

module smooth_number_generator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // item input
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          operation,
    input  wire logic [sng_pkg::IDX_W-1:0]     prime_index,
    input  wire logic [sng_pkg::PRIME_W-1:0]   prime_value,
    input  wire logic [sng_pkg::POS_W-1:0]     sequence_position,
    // item output
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [sng_pkg::VALUE_W-1:0]        result_value,
    output logic                               status,
    // prime_count register write
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sng_pkg::CNT_W-1:0]     cfg_data
);

    sng_pkg::cmd_t cmd;
    logic          pipe_busy;

    // sequencing, counters, prime_count and output valid
    sng_controller u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .operation         (operation),
        .sequence_position (sequence_position),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .pipe_busy         (pipe_busy),
        .cmd               (cmd)
    );

    // memories, multiplier, minimum and result payload
    sng_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .prime_index  (prime_index),
        .prime_value  (prime_value),
        .pipe_busy    (pipe_busy),
        .result_value (result_value),
        .status       (status)
    );

endmodule

`default_nettype wire
